### hw/rtl/dsi_pkg.sv
// ---------------------------------------------------------------------------
// dsi_pkg
// Shared types and constants for the decimal string to int64 converter.
// ---------------------------------------------------------------------------
`default_nettype none

package dsi_pkg;

   localparam int unsigned QueueDepth = 4;

   localparam logic [15:0] ChSpaceBelow  = 16'h0021;
   localparam logic [15:0] ChAsciiTop    = 16'h007E;
   localparam logic [15:0] ChLatinSpace  = 16'h00A1;
   localparam logic [15:0] ChGenSpaceLo  = 16'h2000;
   localparam logic [15:0] ChGenSpaceHi  = 16'h200B;
   localparam logic [15:0] ChIdeoSpace   = 16'h3000;
   localparam logic [15:0] ChPlus        = 16'h002B;
   localparam logic [15:0] ChMinus       = 16'h002D;
   localparam logic [15:0] ChZero        = 16'h0030;
   localparam logic [15:0] ChNine        = 16'h0039;

   localparam logic [63:0] MagLimitDiv10 = 64'd922337203685477580;
   localparam logic [63:0] MaxPos        = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] MinNeg        = 64'h8000_0000_0000_0000;
   localparam logic [3:0]  ClampDigit    = 4'd7;

   typedef struct packed {
      logic [15:0] ch;
      logic        last;
   } req_type;

   typedef struct packed {
      logic signed [63:0] value;
      logic               saturated;
      logic               no_digits;
   } rsp_type;

   typedef enum logic [1:0] {
      CLS_SPACE,
      CLS_SIGN,
      CLS_DIGIT,
      CLS_OTHER
   } cls_type;

   typedef struct packed {
      cls_type    kind;
      logic       minus;
      logic [3:0] digit;
      logic       last;
   } tok_type;

   typedef enum logic [1:0] {
      PH_LEAD,
      PH_SIGNWS,
      PH_DIGITS,
      PH_DONE
   } phase_type;

endpackage

`default_nettype wire

### hw/rtl/dsi_front.sv
// ---------------------------------------------------------------------------
// dsi_front
// Accepts characters and classifies each into a token for the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module dsi_front (
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  dsi_pkg::req_type      req_payload,
   input  wire logic             q_full,
   output logic                  push,
   output dsi_pkg::tok_type      tok
);

   logic [15:0] c;
   logic        is_space;
   logic        is_digit;
   logic        is_sign;

   assign c = req_payload.ch;

   assign is_space = (c < dsi_pkg::ChSpaceBelow) ||
                     (c > dsi_pkg::ChAsciiTop && c < dsi_pkg::ChLatinSpace) ||
                     (c >= dsi_pkg::ChGenSpaceLo && c <= dsi_pkg::ChGenSpaceHi) ||
                     (c == dsi_pkg::ChIdeoSpace);
   assign is_digit = (c >= dsi_pkg::ChZero) && (c <= dsi_pkg::ChNine);
   assign is_sign  = (c == dsi_pkg::ChPlus) || (c == dsi_pkg::ChMinus);

   always_comb begin
      tok.minus = (c == dsi_pkg::ChMinus);
      tok.digit = c[3:0];
      tok.last  = req_payload.last;
      if (is_space) begin
         tok.kind = dsi_pkg::CLS_SPACE;
      end else if (is_sign) begin
         tok.kind = dsi_pkg::CLS_SIGN;
      end else if (is_digit) begin
         tok.kind = dsi_pkg::CLS_DIGIT;
      end else begin
         tok.kind = dsi_pkg::CLS_OTHER;
      end
   end

   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

endmodule

`default_nettype wire

### hw/rtl/dsi_queue.sv
// ---------------------------------------------------------------------------
// dsi_queue
// Small token FIFO between the classifier and the parser.
// ---------------------------------------------------------------------------
`default_nettype none

module dsi_queue #(
   parameter int unsigned Depth = dsi_pkg::QueueDepth
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  dsi_pkg::tok_type push_tok,
   output logic             full,
   output logic             q_valid,
   input  wire logic        pop,
   output dsi_pkg::tok_type q_tok
);

   localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CountW = $clog2(Depth + 1);
   localparam logic [AddrW-1:0]  LastAddr  = AddrW'(Depth - 1);
   localparam logic [CountW-1:0] FullCount = CountW'(Depth);

   dsi_pkg::tok_type  mem_ff [Depth];
   logic [AddrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AddrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;

   assign full    = (count_ff == FullCount);
   assign q_valid = (count_ff != '0);
   assign q_tok   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastAddr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastAddr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_tok;
      end
   end

`ifndef ASSERT_OFF
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCount)
      else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

### hw/rtl/dsi_back.sv
// ---------------------------------------------------------------------------
// dsi_back
// Parser: sign and digit accumulation with clamp, and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module dsi_back (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_valid,
   input  dsi_pkg::tok_type q_tok,
   output logic             pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output dsi_pkg::rsp_type rsp_payload
);

   dsi_pkg::phase_type phase_ff, phase_in;
   logic               neg_ff, neg_in;
   logic [63:0]        acc_ff, acc_in;
   logic               clamped_ff, clamped_in;
   logic               seen_ff, seen_in;
   logic               rsp_valid_ff, rsp_valid_in;
   dsi_pkg::rsp_type   rsp_ff, rsp_in;

   logic               take_digit;
   logic [3:0]         clamp_at;
   logic               over;
   logic [63:0]        acc_next;

   assign pop = q_valid && (!q_tok.last || !rsp_valid_ff || !rsp_stall);

   assign clamp_at = dsi_pkg::ClampDigit + {3'b000, neg_ff};
   assign over     = (acc_ff > dsi_pkg::MagLimitDiv10) ||
                     (acc_ff == dsi_pkg::MagLimitDiv10 && q_tok.digit >= clamp_at);
   assign acc_next = (acc_ff << 3) + (acc_ff << 1) + {60'd0, q_tok.digit};

   always_comb begin
      phase_in     = phase_ff;
      neg_in       = neg_ff;
      acc_in       = acc_ff;
      clamped_in   = clamped_ff;
      seen_in      = seen_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      take_digit   = 1'b0;

      if (pop) begin
         unique case (phase_ff)
            dsi_pkg::PH_LEAD: begin
               unique case (q_tok.kind)
                  dsi_pkg::CLS_SPACE: ;
                  dsi_pkg::CLS_SIGN: begin
                     neg_in   = q_tok.minus;
                     phase_in = dsi_pkg::PH_SIGNWS;
                  end
                  dsi_pkg::CLS_DIGIT: take_digit = 1'b1;
                  default: phase_in = dsi_pkg::PH_DONE;
               endcase
            end
            dsi_pkg::PH_SIGNWS: begin
               unique case (q_tok.kind)
                  dsi_pkg::CLS_SPACE: ;
                  dsi_pkg::CLS_DIGIT: take_digit = 1'b1;
                  default: phase_in = dsi_pkg::PH_DONE;
               endcase
            end
            dsi_pkg::PH_DIGITS: begin
               if (q_tok.kind == dsi_pkg::CLS_DIGIT) begin
                  take_digit = 1'b1;
               end else begin
                  phase_in = dsi_pkg::PH_DONE;
               end
            end
            default: ;
         endcase

         if (take_digit) begin
            seen_in  = 1'b1;
            phase_in = dsi_pkg::PH_DIGITS;
            if (!clamped_ff) begin
               if (over) begin
                  clamped_in = 1'b1;
               end else begin
                  acc_in = acc_next;
               end
            end
         end

         if (q_tok.last) begin
            rsp_valid_in        = 1'b1;
            rsp_in.saturated    = seen_in && clamped_in;
            rsp_in.no_digits    = !seen_in;
            if (!seen_in) begin
               rsp_in.value = '0;
            end else if (clamped_in) begin
               rsp_in.value = neg_in ? dsi_pkg::MinNeg : dsi_pkg::MaxPos;
            end else begin
               rsp_in.value = neg_in ? (64'd0 - acc_in) : acc_in;
            end
            phase_in   = dsi_pkg::PH_LEAD;
            neg_in     = 1'b0;
            acc_in     = '0;
            clamped_in = 1'b0;
            seen_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= dsi_pkg::PH_LEAD;
         neg_ff       <= 1'b0;
         acc_ff       <= '0;
         clamped_ff   <= 1'b0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         neg_ff       <= neg_in;
         acc_ff       <= acc_in;
         clamped_ff   <= clamped_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef ASSERT_OFF
   a_lead_clean: assert property (@(posedge clock) disable iff (reset)
      phase_ff == dsi_pkg::PH_LEAD |-> (acc_ff == '0 && !clamped_ff && !seen_ff))
      else $error("leading phase with digit state");
   a_clamp_seen: assert property (@(posedge clock) disable iff (reset)
      clamped_ff |-> seen_ff)
      else $error("clamp without digit");
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.saturated && rsp_ff.no_digits))
      else $error("saturated and no_digits together");
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.no_digits) |-> rsp_ff.value == '0)
      else $error("no_digits result not zero");
`endif

endmodule

`default_nettype wire

### hw/rtl/decimal_string_to_int64.sv
// ---------------------------------------------------------------------------
// decimal_string_to_int64
// Saturating decimal string to signed 64-bit integer converter.
// ---------------------------------------------------------------------------
// One 16-bit code unit is taken per cycle while the queue is not full; the
// string's last unit carries last=1 and yields one result (value, saturated,
// no_digits) in the result register after the queue and the parser. A
// classifier feeds a small token queue (QueueDepth entries) that drains into
// the parser; its multiply-by-ten, add and clamp compare are combinational,
// so the sustained rate is one code unit per cycle while rsp_stall is low.
`default_nettype none

module decimal_string_to_int64 #(
   parameter int unsigned QueueDepth = dsi_pkg::QueueDepth
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  dsi_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output dsi_pkg::rsp_type rsp_payload
);

   logic             q_full;
   logic             push;
   dsi_pkg::tok_type push_tok;
   logic             q_valid;
   logic             pop;
   dsi_pkg::tok_type q_tok;

   dsi_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_full      (q_full),
      .push        (push),
      .tok         (push_tok)
   );

   dsi_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_tok (push_tok),
      .full     (q_full),
      .q_valid  (q_valid),
      .pop      (pop),
      .q_tok    (q_tok)
   );

   dsi_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_tok       (q_tok),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

### bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the decimal string to int64 converter.
// ---------------------------------------------------------------------------
// A short table of code units hits the whitespace classes, sign handling,
// early termination and empty strings. Random strings follow: mostly
// well-formed numbers with random padding, signs, lengths and values at the
// int64 clamp boundary, mixed with noise. Every accepted code unit runs
// through a behavioral parser kept in the bench; each result is compared
// field by field with the oldest pending one. Both sides idle at random.
// ---------------------------------------------------------------------------

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NumDirected = 25;
   localparam int RandomUnits = 1400;
   localparam int IdleLimit   = 2000;
   localparam int DrainCycles = 10;

   typedef struct packed {
      logic [15:0]        ch;
      logic               last;
      logic               typed;
      logic signed [63:0] v;
      logic               sat;
      logic               nod;
      logic               drain;
   } unit_row_type;

   localparam unit_row_type DirectedTbl [NumDirected] = '{
      '{16'h0035,             1'b1, 1'b1, 64'sd5, 1'b0, 1'b0, 1'b0},
      '{16'h0000,             1'b1, 1'b1, 64'sd0, 1'b0, 1'b1, 1'b0},
      '{16'hFFFF,             1'b1, 1'b1, 64'sd0, 1'b0, 1'b1, 1'b0},
      '{dsi_pkg::ChIdeoSpace,  1'b0, 1'b0, 64'sd0, 1'b0, 1'b0, 1'b0},
      '{dsi_pkg::ChMinus,      1'b0, 1'b0, 64'sd0, 1'b0, 1'b0, 1'b0},
      '{dsi_pkg::ChGenSpaceHi, 1'b0, 1'b0, 64'sd0, 1'b0, 1'b0, 1'b0},
      '{16'h0037,             1'b1, 1'b0, 64'sd0, 1'b0, 1'b0, 1'b0},
      '{dsi_pkg::ChPlus,       1'b0, 1'b0, 64'sd0, 1'b0, 1'b0, 1'b0},
      '{16'h00A0,             1'b0, 1'b0, 64'sd0, 1'b0, 1'b0, 1'b0},
      '{dsi_pkg::ChPlus,       1'b0, 1'b0, 64'sd0, 1'b0, 1'b0, 1'b0},
      '{16'h0031,             1'b1, 1'b1, 64'sd0, 1'b0, 1'b1, 1'b0},
      '{16'h0031,             1'b0, 1'b0, 64'sd0, 1'b0, 1'b0, 1'b0},
      '{16'h0032,             1'b0, 1'b0, 64'sd0, 1'b0, 1'b0, 1'b0},
      '{dsi_pkg::ChMinus,      1'b0, 1'b0, 64'sd0, 1'b0, 1'b0, 1'b0},
      '{16'h0033,             1'b1, 1'b0, 64'sd0, 1'b0, 1'b0, 1'b0},
      '{16'h0020,             1'b0, 1'b0, 64'sd0, 1'b0, 1'b0, 1'b0},
      '{16'h007F,             1'b0, 1'b0, 64'sd0, 1'b0, 1'b0, 1'b0},
      '{dsi_pkg::ChGenSpaceLo, 1'b0, 1'b0, 64'sd0, 1'b0, 1'b0, 1'b0},
      '{16'h200C,             1'b0, 1'b0, 64'sd0, 1'b0, 1'b0, 1'b0},
      '{dsi_pkg::ChNine,       1'b1, 1'b0, 64'sd0, 1'b0, 1'b0, 1'b0},
      '{dsi_pkg::ChLatinSpace, 1'b0, 1'b0, 64'sd0, 1'b0, 1'b0, 1'b0},
      '{16'h0031,             1'b1, 1'b0, 64'sd0, 1'b0, 1'b0, 1'b0},
      '{dsi_pkg::ChMinus,      1'b0, 1'b0, 64'sd0, 1'b0, 1'b0, 1'b0},
      '{dsi_pkg::ChZero,       1'b1, 1'b1, 64'sd0, 1'b0, 1'b0, 1'b0},
      '{dsi_pkg::ChMinus,      1'b1, 1'b1, 64'sd0, 1'b0, 1'b1, 1'b0}
   };

   localparam logic [15:0] BorderUnits [16] = '{
      16'h0020, 16'h0021, 16'h007E, 16'h007F, 16'h00A0, 16'h00A1, 16'h1FFF, 16'h2000,
      16'h200B, 16'h200C, 16'h2FFF, 16'h3000, 16'h3001, 16'h002F, 16'h003A, 16'h002C
   };

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   dsi_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   dsi_pkg::rsp_type rsp_payload;

   decimal_string_to_int64 uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // parser state
   dsi_pkg::phase_type ph          = dsi_pkg::PH_LEAD;
   logic               minus_seen  = 1'b0;
   logic [63:0]        magnitude   = '0;
   logic               clamp_hit   = 1'b0;
   logic               digit_hit   = 1'b0;

   unit_row_type       unit_q [$];
   dsi_pkg::rsp_type   parsed_q [$];
   unit_row_type       cur_row     = '0;

   int errors       = 0;
   int idle_cycles  = 0;
   int units_in     = 0;
   int strings_done = 0;
   int clamp_count  = 0;
   int neg_count    = 0;
   int empty_count  = 0;
   int hold_left    = 0;
   int free_left    = 0;
   int roll         = 0;

   task automatic flag_mismatch(input string what, input logic signed [63:0] got,
                                input logic signed [63:0] want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic bit is_blank(input logic [15:0] c);
      return c < dsi_pkg::ChSpaceBelow ||
             (c > dsi_pkg::ChAsciiTop && c < dsi_pkg::ChLatinSpace) ||
             (c >= dsi_pkg::ChGenSpaceLo && c <= dsi_pkg::ChGenSpaceHi) ||
             c == dsi_pkg::ChIdeoSpace;
   endfunction

   function automatic void add_digit(input logic [3:0] d);
      digit_hit = 1'b1;
      ph        = dsi_pkg::PH_DIGITS;
      if (!clamp_hit) begin
         if (magnitude > dsi_pkg::MagLimitDiv10 ||
             (magnitude == dsi_pkg::MagLimitDiv10 &&
              int'(d) >= int'(dsi_pkg::ClampDigit) + int'(minus_seen)))
            clamp_hit = 1'b1;
         else
            magnitude = magnitude * 64'd10 + 64'(d);
      end
   endfunction

   // Advance the parser by one code unit; returns 1 with the value on last.
   function automatic bit parse_unit(input dsi_pkg::req_type r,
                                     output dsi_pkg::rsp_type res);
      logic isdig;
      isdig = r.ch >= dsi_pkg::ChZero && r.ch <= dsi_pkg::ChNine;
      res   = '0;
      case (ph)
         dsi_pkg::PH_LEAD: begin
            if (is_blank(r.ch)) begin
            end else if (r.ch == dsi_pkg::ChMinus || r.ch == dsi_pkg::ChPlus) begin
               minus_seen = (r.ch == dsi_pkg::ChMinus);
               ph         = dsi_pkg::PH_SIGNWS;
            end else if (isdig) begin
               add_digit(r.ch[3:0]);
            end else begin
               ph = dsi_pkg::PH_DONE;
            end
         end
         dsi_pkg::PH_SIGNWS: begin
            if (is_blank(r.ch)) begin
            end else if (isdig) begin
               add_digit(r.ch[3:0]);
            end else begin
               ph = dsi_pkg::PH_DONE;
            end
         end
         dsi_pkg::PH_DIGITS: begin
            if (isdig)
               add_digit(r.ch[3:0]);
            else
               ph = dsi_pkg::PH_DONE;
         end
         default: begin
         end
      endcase
      if (!r.last)
         return 1'b0;
      if (!digit_hit)
         res.value = '0;
      else if (clamp_hit)
         res.value = minus_seen ? dsi_pkg::MinNeg : dsi_pkg::MaxPos;
      else
         res.value = minus_seen ? 64'd0 - magnitude : magnitude;
      res.saturated = digit_hit && clamp_hit;
      res.no_digits = !digit_hit;
      ph         = dsi_pkg::PH_LEAD;
      minus_seen = 1'b0;
      magnitude  = '0;
      clamp_hit  = 1'b0;
      digit_hit  = 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [15:0] blank_unit();
      case ($urandom_range(0, 3))
         0:       return 16'($urandom_range(0, 32));
         1:       return 16'($urandom_range(16'h007F, 16'h00A0));
         2:       return 16'($urandom_range(dsi_pkg::ChGenSpaceLo, dsi_pkg::ChGenSpaceHi));
         default: return dsi_pkg::ChIdeoSpace;
      endcase
   endfunction

   function automatic logic [15:0] odd_unit();
      case ($urandom_range(0, 4))
         0, 1:    return 16'($urandom_range(0, 65535));
         2:       return BorderUnits[$urandom_range(0, 15)];
         3:       return blank_unit();
         default: return 16'($urandom_range(16'h0021, 16'h007E));
      endcase
   endfunction

   function automatic logic [15:0] digit_unit(input int d);
      return dsi_pkg::ChZero + 16'(d);
   endfunction

   task automatic gen_string(input bit hold);
      logic [15:0] units [$];
      string       lim;
      int          len;
      int          mode;
      lim = "922337203685477580";
      if ($urandom_range(0, 9) < 2) begin
         repeat ($urandom_range(1, 6)) units.push_back(odd_unit());
      end else begin
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) units.push_back(blank_unit());
         case ($urandom_range(0, 3))
            1:       units.push_back(dsi_pkg::ChPlus);
            2, 3:    units.push_back(dsi_pkg::ChMinus);
            default: begin
            end
         endcase
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 2)) units.push_back(blank_unit());
         if ($urandom_range(0, 15) == 0)
            units.push_back($urandom_range(0, 1) ? dsi_pkg::ChPlus : dsi_pkg::ChMinus);
         mode = $urandom_range(0, 7);
         if (mode < 4)
            len = $urandom_range(0, 6);
         else if (mode == 4)
            len = $urandom_range(7, 18);
         else if (mode == 5)
            len = $urandom_range(19, 22);
         else
            len = 0;
         if (mode == 7)
            repeat ($urandom_range(1, 4)) units.push_back(dsi_pkg::ChZero);
         if (mode >= 6) begin
            for (int i = 0; i < lim.len(); i++)
               units.push_back({8'h00, lim[i]});
            units.push_back(digit_unit($urandom_range(0, 1) ? $urandom_range(6, 8)
                                                          : $urandom_range(0, 9)));
            repeat ($urandom_range(0, 2)) units.push_back(digit_unit($urandom_range(0, 9)));
         end
         repeat (len) units.push_back(digit_unit($urandom_range(0, 9)));
         if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) units.push_back(odd_unit());
      end
      if (units.size() == 0)
         units.push_back(odd_unit());
      foreach (units[i])
         unit_q.push_back('{ch: units[i], last: (i == units.size() - 1),
                            drain: (hold && i == 0), default: '0});
   endtask

   // idle_cycles counts edges with no handshake on either side
   always @(posedge clock) begin
      dsi_pkg::rsp_type got;
      dsi_pkg::rsp_type want;
      bit               moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            units_in++;
            if (parse_unit(req_payload, got)) begin
               if (cur_row.typed)
                  parsed_q.push_back('{value: cur_row.v, saturated: cur_row.sat,
                                       no_digits: cur_row.nod});
               else
                  parsed_q.push_back(got);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (parsed_q.size() == 0) begin
               flag_mismatch("result with nothing pending", rsp_payload.value, 0);
            end else begin
               want = parsed_q.pop_front();
               strings_done++;
               clamp_count += want.saturated;
               empty_count += want.no_digits;
               neg_count   += (want.value < 0);
               if (rsp_payload.value !== want.value)
                  flag_mismatch("value", rsp_payload.value, want.value);
               if (rsp_payload.saturated !== want.saturated)
                  flag_mismatch("saturated", rsp_payload.saturated, want.saturated);
               if (rsp_payload.no_digits !== want.no_digits)
                  flag_mismatch("no_digits", rsp_payload.no_digits, want.no_digits);
            end
         end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
   end

   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall = 1'b1;
      end else if (free_left != 0) begin
         free_left--;
         rsp_stall = 1'b0;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            free_left = $urandom_range(30, 120);
            rsp_stall = 1'b0;
         end else if (roll < 60) begin
            rsp_stall = 1'b0;
         end else if (roll < 93) begin
            hold_left = $urandom_range(0, 2);
            rsp_stall = 1'b1;
         end else begin
            hold_left = $urandom_range(8, 30);
            rsp_stall = 1'b1;
         end
      end
   end

   initial begin
      while (idle_cycles < IdleLimit)
         @(posedge clock);
      $display("FAIL decimal_string_to_int64");
      $finish;
   end

   initial begin
      int gap;
      int calm_left;
      int pick;
      bit mid_marked;
      calm_left  = 0;
      mid_marked = 1'b0;
      foreach (DirectedTbl[i])
         unit_q.push_back(DirectedTbl[i]);
      gen_string(1'b1);
      while (unit_q.size() < NumDirected + RandomUnits) begin
         gen_string(!mid_marked && unit_q.size() >= NumDirected + RandomUnits / 2);
         if (unit_q.size() >= NumDirected + RandomUnits / 2)
            mid_marked = 1'b1;
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (unit_q[i]) begin
         if (unit_q[i].drain) begin
            req_valid = 1'b0;
            while (parsed_q.size() != 0)
               @(negedge clock);
         end
         if (calm_left != 0) begin
            calm_left--;
            gap = 0;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
               calm_left = $urandom_range(20, 80);
               gap       = 0;
            end else if (pick < 60) begin
               gap = 0;
            end else if (pick < 93) begin
               gap = $urandom_range(1, 3);
            end else begin
               gap = $urandom_range(8, 30);
            end
         end
         if (gap != 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         cur_row     = unit_q[i];
         req_payload = '{ch: unit_q[i].ch, last: unit_q[i].last};
         req_valid   = 1'b1;
         do
            @(posedge clock);
         while (req_stall);
         @(negedge clock);
      end
      req_valid = 1'b0;

      while (parsed_q.size() != 0)
         @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      if (parsed_q.size() != 0)
         flag_mismatch("results never arrived", parsed_q.size(), 0);

      $display("%0d code units, %0d strings checked", units_in, strings_done);
      $display("%0d clamped, %0d negative, %0d without digits",
               clamp_count, neg_count, empty_count);
      if (errors == 0)
         $display("PASS decimal_string_to_int64");
      else
         $display("FAIL decimal_string_to_int64");
      $finish;
   end

endmodule

### decimal_string_to_int64.f
hw/rtl/dsi_pkg.sv
hw/rtl/dsi_front.sv
hw/rtl/dsi_queue.sv
hw/rtl/dsi_back.sv
hw/rtl/decimal_string_to_int64.sv
bench/tb_top.sv
